// ===== design/modexp_pkg.sv =====
// Package for the modular exponentiation block: widths and sequencer codes.
// Used by modexp_mulmod.sv and modular_exponentiation.sv.
package modexp_pkg;
  localparam int unsigned WordWidth = 64;
  localparam int unsigned CntWidth  = $clog2(WordWidth + 1);
  typedef logic [WordWidth-1:0] word_t;
  typedef logic [CntWidth-1:0]  cnt_t;

  localparam logic [1:0] CfgExponent = 2'd0;
  localparam logic [1:0] CfgModulus  = 2'd1;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StReduce = 3'd1;
  localparam logic [2:0] StMul    = 3'd2;
  localparam logic [2:0] StSqr    = 3'd3;
  localparam logic [2:0] StOut    = 3'd4;
endpackage

// ===== design/modular_exponentiation.sv =====
// Modular exponentiation, LSB-first square-and-multiply over a bit-serial multiplier.
// The base is reduced first; then, for each exponent bit up to the highest set
// bit, a multiply runs when the bit is set, followed by a square.
// One transaction at a time; input stall is high while a word is in flight.
// The result sits in an output register until taken. Synchronous active-high
// reset sets exponent 1, modulus 2 and idles the sequencer.
module modular_exponentiation (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [modexp_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  logic [63:0]                          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [63:0]                          base_word,
  input  logic                                 last_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [63:0]                          result_word,
  output logic                                 last_out
);
  logic [2:0]        state;
  modexp_pkg::word_t exponent, modulus;
  modexp_pkg::word_t acc, rbase, eshift;
  logic              last_q;
  logic              mm_start, mm_done;
  modexp_pkg::word_t mm_a, mm_b, mm_r;

  assign in_stall = (state != modexp_pkg::StIdle);

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= modexp_pkg::word_t'(1);
      modulus  <= modexp_pkg::word_t'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        modexp_pkg::CfgExponent: exponent <= cfg_data[modexp_pkg::WordWidth-1:0];
        modexp_pkg::CfgModulus:  modulus  <= cfg_data[modexp_pkg::WordWidth-1:0];
        default: ;
      endcase
    end
  end

  // base reduction reuses the multiplier as 1*base mod m (restoring remainder)
  always_comb begin
    mm_a = acc;
    mm_b = rbase;
    unique case (state)
      modexp_pkg::StReduce: begin mm_a = modexp_pkg::word_t'(1); mm_b = rbase; end
      modexp_pkg::StSqr:    begin mm_a = rbase; mm_b = rbase; end
      default: ;
    endcase
  end

  modexp_mulmod u_mm (
    .clk(clk), .rst(rst), .start(mm_start), .a(mm_a), .b(mm_b), .m(modulus),
    .done(mm_done), .r(mm_r)
  );

  logic pending; // multiplier launched for current state
  assign mm_start = !pending && (state == modexp_pkg::StReduce ||
                    state == modexp_pkg::StMul || state == modexp_pkg::StSqr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= modexp_pkg::StIdle;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (mm_start) pending <= 1'b1;
      unique case (state)
        modexp_pkg::StIdle: begin
          if (in_valid) begin
            rbase  <= base_word[modexp_pkg::WordWidth-1:0];
            eshift <= exponent;
            last_q <= last_in;
            // 1 mod m: zero when m is one (or zero)
            acc    <= (modulus > modexp_pkg::word_t'(1)) ? modexp_pkg::word_t'(1) : '0;
            state  <= (modulus == '0) ? modexp_pkg::StOut : modexp_pkg::StReduce;
          end
        end
        modexp_pkg::StReduce: if (mm_done) begin
          rbase   <= mm_r;
          pending <= 1'b0;
          state   <= (eshift == '0) ? modexp_pkg::StOut :
                     eshift[0] ? modexp_pkg::StMul : modexp_pkg::StSqr;
        end
        modexp_pkg::StMul: if (mm_done) begin
          acc     <= mm_r;
          pending <= 1'b0;
          state   <= modexp_pkg::StSqr;
        end
        modexp_pkg::StSqr: if (mm_done) begin
          rbase   <= mm_r;
          pending <= 1'b0;
          eshift  <= eshift >> 1;
          state   <= ((eshift >> 1) == '0) ? modexp_pkg::StOut :
                     eshift[1] ? modexp_pkg::StMul : modexp_pkg::StSqr;
        end
        modexp_pkg::StOut: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            result_word <= 64'(acc);
            last_out    <= last_q;
            state       <= modexp_pkg::StIdle;
          end
        end
        default: state <= modexp_pkg::StIdle;
      endcase
      if (out_valid && !out_stall && state != modexp_pkg::StOut) out_valid <= 1'b0;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != modexp_pkg::StIdle) |-> in_stall) else $error("accept while busy");
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == modexp_pkg::StIdle) |-> !pending) else $error("multiplier left running");
  a_out_from_outstate: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == modexp_pkg::StOut) else $error("bad out");
endmodule

// ===== design/modexp_mulmod.sv =====
// Bit-serial modular multiplier: r = a*b mod m, one multiplier bit per cycle, MSB first.
// Depends on modexp_pkg.
module modexp_mulmod (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  modexp_pkg::word_t   a,
  input  modexp_pkg::word_t   b,
  input  modexp_pkg::word_t   m,
  output logic                done,
  output modexp_pkg::word_t   r
);
  modexp_pkg::word_t bsh;
  modexp_pkg::cnt_t  cnt;
  logic              busy;
  modexp_pkg::word_t acc_dbl, acc_add;
  logic [modexp_pkg::WordWidth:0] s1, s2;

  // doubling then conditional add, each reduced by one compare-subtract
  always_comb begin
    s1 = {r, 1'b0};
    if (s1 >= {1'b0, m}) s1 = s1 - {1'b0, m};
    acc_dbl = s1[modexp_pkg::WordWidth-1:0];
    s2 = {1'b0, acc_dbl} + {1'b0, a};
    if (s2 >= {1'b0, m}) s2 = s2 - {1'b0, m};
    acc_add = bsh[modexp_pkg::WordWidth-1] ? s2[modexp_pkg::WordWidth-1:0] : acc_dbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= modexp_pkg::CntWidth'(modexp_pkg::WordWidth);
      bsh  <= b;
      r    <= '0;
      done <= 1'b0;
    end else if (busy) begin
      r    <= acc_add;
      bsh  <= bsh << 1;
      cnt  <= cnt - 1'b1;
      busy <= (cnt != modexp_pkg::CntWidth'(1));
      done <= (cnt == modexp_pkg::CntWidth'(1));
    end else begin
      done <= 1'b0;
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without busy");
  a_cnt_zero_idle: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !done) else $error("spurious done");
  a_result_below_mod: assert property (@(posedge clk) disable iff (rst)
    (done && m != '0) |-> r < m) else $error("result not reduced");
endmodule

// ===== tb/sv/modular_exponentiation_tb.sv =====
// Self-checking testbench for modular_exponentiation: random and directed words,
// predicted by a square-and-multiply model. Depends on modexp_pkg and the DUT.
module modular_exponentiation_tb;

  localparam int unsigned WatchdogLimit = 200000;

  // expected result of one transaction
  typedef struct {
    logic [63:0] word;
    logic        last;
  } modexp_result_t;

  // pending input word for the driver
  typedef struct {
    logic [63:0] word;
    logic        last;
  } base_item_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [modexp_pkg::CfgIdxWidth-1:0] cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] base_word;
  logic        last_in;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] result_word;
  logic        last_out;

  modular_exponentiation i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .base_word(base_word), .last_in(last_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_word(result_word), .last_out(last_out)
  );

  // predictor copy of the configuration
  logic [63:0] exp_cfg;
  logic [63:0] mod_cfg;

  base_item_t     pending_words[$];
  modexp_result_t expected_results[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  quiet_stretch;  // disables random idling on both sides
  bit  timed_out = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // (a + b) mod m with a, b < m; the 65-bit sum covers the carry
  function automatic logic [63:0] add_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[63:0];
  endfunction

  // shift-and-add modular product
  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [63:0] r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = add_mod(r, r, m);
      if (b[i]) r = add_mod(r, a, m);
    end
    return r;
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    if (m == 0) return '0;
    acc = (m == 1) ? 64'd0 : 64'd1;
    sq  = b % m;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, sq, m);
      sq = mul_mod(sq, sq, m);
      e  = e >> 1;
    end
    return acc;
  endfunction

  // driver: one transaction from the queue, random idle gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_words.size() > 0 && (quiet_stretch || $urandom_range(99) >= 16)) begin
        base_item_t it;
        it = pending_words.pop_front();
        in_valid  <= 1'b1;
        base_word <= it.word;
        last_in   <= it.last;
        expected_results = {expected_results,
                            modexp_result_t'{pow_mod(it.word, exp_cfg, mod_cfg), it.last}};
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, independent of valid
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else     out_stall <= !quiet_stretch && ($urandom_range(99) < 16);
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word=%h last=%b", result_word, last_out);
      end else begin
        modexp_result_t e;
        e = expected_results.pop_front();
        if (e.word !== result_word || e.last !== last_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected word=%h last=%b, got word=%h last=%b",
                     e.word, e.last, result_word, last_out);
        end
      end
    end
  end

  // watchdog: counts cycles with no accepted transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog timeout");
      $display("FAIL modular_exponentiation");
      $finish;
    end
  end

  // one write, then cfg_we is held low before returning so back-to-back writes never collide
  task automatic write_reg(logic [modexp_pkg::CfgIdxWidth-1:0] idx, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == modexp_pkg::CfgExponent) exp_cfg = value;
    else                                mod_cfg = value;
    @(posedge clk);
  endtask

  // wait for the queue to drain and every result to come back
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_word(logic [63:0] w, logic l);
    pending_words = {pending_words, base_item_t'{w, l}};
  endtask

  // random words; mostly short exponents keep the run fast
  task automatic random_phase(int n, logic [63:0] e, logic [63:0] m);
    write_reg(modexp_pkg::CfgExponent, e);
    write_reg(modexp_pkg::CfgModulus, m);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0:       queue_word(rand64() % m, 1'($urandom_range(1)));
        1:       queue_word(m + 64'($urandom_range(3)), 1'($urandom_range(1)));
        default: queue_word(rand64(), 1'($urandom_range(1)));
      endcase
    end
    drain();
  endtask

  initial begin
    logic [63:0] max_word;
    max_word      = '1;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    quiet_stretch = 1'b0;
    exp_cfg       = 64'd1;
    mod_cfg       = 64'd2;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration: exponent 1, modulus 2
    queue_word(64'd3, 1'b0);
    queue_word(max_word, 1'b1);
    drain();

    // directed: extremes, exponent zero, modulus one and zero, base above modulus
    write_reg(modexp_pkg::CfgExponent, 64'd0);
    write_reg(modexp_pkg::CfgModulus, 64'd97);
    queue_word(64'd5, 1'b1);
    queue_word(64'd0, 1'b0);
    drain();
    write_reg(modexp_pkg::CfgExponent, 64'd65537);
    write_reg(modexp_pkg::CfgModulus, 64'd1);
    queue_word(64'd12345, 1'b0);
    drain();
    write_reg(modexp_pkg::CfgModulus, 64'd0);
    queue_word(64'd7, 1'b1);
    drain();
    write_reg(modexp_pkg::CfgModulus, 64'hFFFF_FFFF_FFFF_FFC5);  // largest 64-bit prime
    queue_word(max_word, 1'b0);
    queue_word(64'hFFFF_FFFF_FFFF_FFC5, 1'b1);
    queue_word(64'd2, 1'b0);
    queue_word(64'd0, 1'b1);
    drain();
    write_reg(modexp_pkg::CfgExponent, max_word);  // full-length exponent, slowest case
    write_reg(modexp_pkg::CfgModulus, max_word);
    queue_word(64'h8000_0000_0000_0001, 1'b1);
    queue_word(64'hDEAD_BEEF_CAFE_F00D, 1'b0);
    drain();
    write_reg(modexp_pkg::CfgExponent, 64'd2);
    write_reg(modexp_pkg::CfgModulus, 64'd2);
    queue_word(64'd3, 1'b0);
    queue_word(64'd4, 1'b1);
    drain();

    // random phases across several settings, one without idling
    random_phase(25, {48'd0, 16'($urandom())}, rand64() | 64'h8000_0000_0000_0000);
    random_phase(25, 64'd65537, {32'd0, $urandom()} | 64'd2);
    quiet_stretch = 1'b1;
    random_phase(25, {44'd0, 20'($urandom())}, rand64() | 64'd3);
    quiet_stretch = 1'b0;
    random_phase(15, {56'd0, 8'($urandom())}, 64'd3 + 64'($urandom_range(200)));
    random_phase(8, rand64(), rand64() | 64'd2);

    if (mismatches == 0) $display("PASS modular_exponentiation");
    else                 $display("FAIL modular_exponentiation");
    $finish;
  end
endmodule
